>>> hw/rtl/bbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants of the streaming 3x3 box blur.
// ----------------------------------------------------------------------------
package bbl_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 1024;

	localparam int CFG_W    = 11;
	localparam int PIX_W    = 24;
	localparam int CH_W     = 8;
	localparam int SUM_W    = 12;
	localparam int OUT_XY_W = 10;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd600;
	localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

	// floor(s / 9) = (s * 3641) >> 15 for s up to 9 * 255
	localparam logic [SUM_W-1:0] RECIP_NINE  = 12'd3641;
	localparam int               RECIP_SHIFT = 15;
	localparam logic [SUM_W-1:0] SUM_MAX     = 12'd2295;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] pixel_color;
		logic        is_flush;
	} pixel_word_t;

	typedef struct packed {
		logic [31:0]         out_color;
		logic [OUT_XY_W-1:0] out_x;
		logic [OUT_XY_W-1:0] out_y;
		logic                frame_last;
	} blur_word_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} edge_keep_t;

endpackage

>>> hw/rtl/bbl_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_stream_if
// Valid/ready stream channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface bbl_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hw/rtl/bbl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_cell
// One window cell: holds an RGB pixel, takes its neighbor's on a shift and zeroes on a clear.
// ----------------------------------------------------------------------------
module bbl_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bbl_pkg::cell_ctrl_t      ctrl,
	input  logic [bbl_pkg::PIX_W-1:0] din,
	output logic [bbl_pkg::PIX_W-1:0] dout
);
	import bbl_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (ctrl.clear) begin
			dout <= '0;
		end else if (ctrl.shift) begin
			dout <= din;
		end
	end
endmodule

>>> hw/rtl/box_blur_3x3_rgb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// Streaming 3x3 box blur of an RGBA8888 raster with two row stores and a
// 3x3 chain of window cells.
// ----------------------------------------------------------------------------
//  channel   dir  word          handshake
//  pixels    in   pixel_word_t  valid/ready
//  blurred   out  blur_word_t   valid/ready
//  cfg       in   index, data   cfg_write strobe, no read-back
//
//  one word per clock unless the output stalls the stages; a result is
//  registered in row store read, window shift, channel sums, divide by 9
//  reset: frame 800x600, position (0,0), window zero; row stores not cleared
//  each stage advances when the next one is free; ready drops only when the
//  row store stage is held
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  bbl_pkg::cfg_reg_t         cfg_index,
	input  logic [bbl_pkg::CFG_W-1:0] cfg_data,
	bbl_stream_if.sink                pixels,
	bbl_stream_if.source              blurred
);
	import bbl_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = XW + 1;

	logic [CFG_W-1:0] width_q, height_q;
	logic [WW-1:0]    wd;
	logic [CFG_W-1:0] ht;

	logic [XW-1:0]    x_q;
	logic [CFG_W-1:0] y_q;

	logic             acc, adv_s1, adv_s2, adv_s3;
	logic             row_start, emit_now, last_now;
	logic [XW-1:0]    cx_now;
	logic [CFG_W-1:0] cy_now;
	edge_keep_t       keep_now;

	logic             v_s1, emit_s1, last_s1, byp_s1;
	logic [PIX_W-1:0] pix_s1, byp_up_s1, byp_mid_s1;
	logic [XW-1:0]    x_s1, cx_s1;
	logic [OUT_XY_W-1:0] cy_s1;
	edge_keep_t       keep_s1;
	logic [PIX_W-1:0] up_rd, mid_rd, a_s1, b_s1;

	logic             v_s2, last_s2;
	logic [XW-1:0]    cx_s2;
	logic [OUT_XY_W-1:0] cy_s2;
	edge_keep_t       keep_s2;

	logic             v_s3, last_s3;
	logic [XW-1:0]    cx_s3;
	logic [OUT_XY_W-1:0] cy_s3;
	logic [SUM_W-1:0] sum_s3 [3];

	logic             out_v_q;
	blur_word_t       out_q;

	cell_ctrl_t       cell_ctrl;
	logic [PIX_W-1:0] row_in [3];
	logic [PIX_W-1:0] cell_q [3][3];
	logic [2:0]       keep_row, keep_col;
	logic [SUM_W-1:0] sum_now [3];
	logic [2*SUM_W-1:0] prod [3];
	logic [CH_W-1:0]  quot [3];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			wd = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wd = WW'(MAX_WIDTH);
		end else begin
			wd = WW'(width_q);
		end
		if (height_q == '0) begin
			ht = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			ht = CFG_W'(MAX_HEIGHT);
		end else begin
			ht = height_q;
		end
	end

	// handshake
	assign adv_s3       = v_s3 && (!out_v_q || blurred.ready);
	assign adv_s2       = v_s2 && (!v_s3 || adv_s3);
	assign adv_s1       = v_s1 && (!v_s2 || adv_s2);
	assign pixels.ready = !v_s1 || adv_s1;
	assign acc          = pixels.valid && pixels.ready;

	// window position of the incoming word
	always_comb begin
		row_start       = (x_q == '0);
		emit_now        = row_start ? (y_q >= CFG_W'(2) && y_q <= ht + CFG_W'(1))
		                            : (y_q >= CFG_W'(1) && y_q <= ht);
		cx_now          = row_start ? XW'(wd - WW'(1)) : x_q - XW'(1);
		cy_now          = y_q - (row_start ? CFG_W'(2) : CFG_W'(1));
		keep_now.left   = (cx_now != '0);
		keep_now.right  = ({1'b0, cx_now} != wd - WW'(1));
		keep_now.top    = (cy_now != '0);
		keep_now.bottom = (cy_now != ht - CFG_W'(1));
		last_now        = row_start && (y_q == ht + CFG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_write) begin
			x_q <= '0;
			y_q <= '0;
		end else if (acc) begin
			if (last_now) begin
				x_q <= '0;
				y_q <= '0;
			end else if ({1'b0, x_q} + WW'(1) == wd) begin
				x_q <= '0;
				y_q <= y_q + CFG_W'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// row stores
	assign a_s1 = byp_s1 ? byp_up_s1 : up_rd;
	assign b_s1 = byp_s1 ? byp_mid_s1 : mid_rd;

	bbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_upper (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (x_s1),
		.wdata (b_s1),
		.re    (acc),
		.raddr (x_q),
		.rdata (up_rd)
	);

	bbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_middle (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (x_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (x_q),
		.rdata (mid_rd)
	);

	// stage 1: row store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= pixels.data.is_flush ? '0 : pixels.data.pixel_color[31:8];
			x_s1       <= x_q;
			emit_s1    <= emit_now;
			cx_s1      <= cx_now;
			cy_s1      <= OUT_XY_W'(cy_now);
			keep_s1    <= keep_now;
			last_s1    <= last_now;
			// same entry written by the word leaving this stage
			byp_s1     <= adv_s1 && (x_s1 == x_q);
			byp_up_s1  <= b_s1;
			byp_mid_s1 <= pix_s1;
		end
	end

	// stage 2: window cells
	assign cell_ctrl.shift = adv_s1;
	assign cell_ctrl.clear = cfg_write;
	assign row_in[0]       = a_s1;
	assign row_in[1]       = b_s1;
	assign row_in[2]       = pix_s1;

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			if (k == 2) begin : g_head
				bbl_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (cell_ctrl),
					.din    (row_in[r]),
					.dout   (cell_q[r][k])
				);
			end else begin : g_link
				bbl_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (cell_ctrl),
					.din    (cell_q[r][k+1]),
					.dout   (cell_q[r][k])
				);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= emit_s1;
		end else if (adv_s2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			keep_s2 <= keep_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: channel sums of the in-frame cells
	assign keep_row = {keep_s2.bottom, 1'b1, keep_s2.top};
	assign keep_col = {keep_s2.right, 1'b1, keep_s2.left};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_now[c] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					if (keep_row[r] && keep_col[k]) begin
						sum_now[c] = sum_now[c] + SUM_W'(cell_q[r][k][(2-c)*CH_W +: CH_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s2) begin
			v_s3 <= 1'b1;
		end else if (adv_s3) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sum_s3  <= sum_now;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			last_s3 <= last_s2;
		end
	end

	// output: divide by 9
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = (2*SUM_W)'(sum_s3[c]) * (2*SUM_W)'(RECIP_NINE);
			quot[c] = prod[c][RECIP_SHIFT +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s3) begin
			out_v_q <= 1'b1;
		end else if (blurred.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			out_q.out_color  <= {quot[0], quot[1], quot[2], ALPHA_OPAQUE};
			out_q.out_x      <= OUT_XY_W'(cx_s3);
			out_q.out_y      <= cy_s3;
			out_q.frame_last <= last_s3;
		end
	end

	assign blurred.valid = out_v_q;
	assign blurred.data  = out_q;

`ifndef ASSERT_OFF
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, x_q} < wd)
		else $error("column position beyond frame width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		y_q <= ht + CFG_W'(1))
		else $error("row position beyond drain row");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_now) |=> (x_q == '0 && y_q == '0))
		else $error("position not restarted after frame end");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sum_s3[0] <= SUM_MAX && sum_s3[1] <= SUM_MAX && sum_s3[2] <= SUM_MAX))
		else $error("channel sum exceeds nine full pixels");
`endif
endmodule
